// ===== src/sbpm_pkg.sv =====
// Shared types, widths and CORDIC constants for the stereo bin phase masker.
// Used by every module of the block; depends on nothing.
package sbpm_pkg;

  localparam int PART_W    = 24;  // complex part width
  localparam int BIN_W     = 10;  // bin index width
  localparam int THR_W     = 17;  // phase threshold register width
  localparam int PHASE_W   = 16;  // phase in 1/65536 turn
  localparam int CFG_W     = 17;  // config write data, widest register
  localparam int CFG_IDX_W = 1;

  // CORDIC datapath: x/y carry the negated -2^23 plus gain growth, z spans
  // half a turn plus the summed angle table in 2^-24 turn units.
  localparam int XW        = 28;
  localparam int ZW        = 26;
  localparam int ITER      = 20;

  localparam int PH_STAGES  = ITER + 2;       // prep, iterations, phase
  localparam int PIPE_DEPTH = PH_STAGES + 1;  // plus decision/output register

  localparam int DEF_BIN_COUNT = 1024;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(8388608);
  localparam logic signed [ZW-1:0] ROUND_BIAS = ZW'(128);
  localparam logic [PHASE_W-1:0]   QUARTER_TURN = PHASE_W'(16384);

  // atan(2^-i) in 2^-24 turn, rounded to nearest
  localparam int CORDIC_ANGLE [ITER] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_THRESHOLD = 1'b0,
    REG_CUTOFF_BIN      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;  // input vector was (0,0)
  } cordic_vec_t;

  typedef struct packed {
    logic signed [PART_W-1:0] left_real;
    logic signed [PART_W-1:0] left_imag;
    logic signed [PART_W-1:0] right_real;
    logic signed [PART_W-1:0] right_imag;
    logic [BIN_W-1:0]         bin_number;
  } bin_payload_t;

endpackage

// ===== src/stereo_bin_phase_masker_core.sv =====
// Stereo bin phase masker. Takes one bin per cycle when not stalled and
// returns it in order, zeroed when left and right phases lie closer than
// phase_threshold (plain difference, 1/65536 turn) and the bin index lies
// above cutoff_bin and below BIN_COUNT; bin 0 always passes. It uses two
// 20-stage CORDIC atan2 pipelines plus fold, rounding and output registers.
// Each stage holds its item until the next frees, so bubbles close up and a
// new request is taken whenever any stage ahead is empty or the output is
// taken. Config writes apply to requests in flight, so write only when idle.
module stereo_bin_phase_masker_core import sbpm_pkg::*; #(
  parameter int BIN_COUNT = DEF_BIN_COUNT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PART_W-1:0] in_left_real,
  input  logic signed [PART_W-1:0] in_left_imag,
  input  logic signed [PART_W-1:0] in_right_real,
  input  logic signed [PART_W-1:0] in_right_imag,
  input  logic [BIN_W-1:0]         in_bin_number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PART_W-1:0] out_left_real,
  output logic signed [PART_W-1:0] out_left_imag,
  output logic signed [PART_W-1:0] out_right_real,
  output logic signed [PART_W-1:0] out_right_imag,
  output logic                     out_removed,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  logic [THR_W-1:0]      thr_r;
  logic [BIN_W-1:0]      cut_r;
  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] adv;
  bin_payload_t          pay_r [PH_STAGES];
  bin_payload_t          pay_in, pay_last;
  logic [PHASE_W-1:0]    ph_left, ph_right, diff;
  logic                  remove;

  logic signed [PART_W-1:0] o_lr_r, o_li_r, o_rr_r, o_ri_r;
  logic                     o_rm_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      cut_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        REG_CUTOFF_BIN:      cut_r <= cfg_wdata[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it or any stage downstream is empty, or out_ready is high
  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_adv
    assign adv[k] = out_ready || !(&v_r[PIPE_DEPTH-1:k]);
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign pay_in = '{left_real:  in_left_real,  left_imag:  in_left_imag,
                    right_real: in_right_real, right_imag: in_right_imag,
                    bin_number: in_bin_number};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pay_r[0] <= pay_in;
    end
    for (int k = 1; k < PH_STAGES; k++) begin
      if (adv[k]) begin
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  sbpm_phase u_phase_left (
    .clk   (clk),
    .en    (adv[PH_STAGES-1:0]),
    .re    (in_left_real),
    .im    (in_left_imag),
    .phase (ph_left)
  );

  sbpm_phase u_phase_right (
    .clk   (clk),
    .en    (adv[PH_STAGES-1:0]),
    .re    (in_right_real),
    .im    (in_right_imag),
    .phase (ph_right)
  );

  assign pay_last = pay_r[PH_STAGES-1];

  always_comb begin
    diff   = (ph_left >= ph_right) ? (ph_left - ph_right) : (ph_right - ph_left);
    remove = ({1'b0, diff} < thr_r) && (pay_last.bin_number > cut_r) &&
             (pay_last.bin_number != '0) &&
             (32'(pay_last.bin_number) < 32'(BIN_COUNT));
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_DEPTH-1]) begin
      o_rm_r <= remove;
      o_lr_r <= remove ? '0 : pay_last.left_real;
      o_li_r <= remove ? '0 : pay_last.left_imag;
      o_rr_r <= remove ? '0 : pay_last.right_real;
      o_ri_r <= remove ? '0 : pay_last.right_imag;
    end
  end

  assign out_valid      = v_r[PIPE_DEPTH-1];
  assign out_left_real  = o_lr_r;
  assign out_left_imag  = o_li_r;
  assign out_right_real = o_rr_r;
  assign out_right_imag = o_ri_r;
  assign out_removed    = o_rm_r;

endmodule

// ===== src/sbpm_cordic_stage.sv =====
// One registered vectoring CORDIC micro-rotation with a fixed shift and angle.
// Depends on sbpm_pkg.
module sbpm_cordic_stage import sbpm_pkg::*; #(
  parameter int SHIFT = 0,
  parameter int ANGLE = CORDIC_ANGLE[0]
) (
  input  logic        clk,
  input  logic        en,
  input  cordic_vec_t vin,
  output cordic_vec_t vout
);

  cordic_vec_t vec_r, vec_nxt;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = vin.x >>> SHIFT;
    dy = vin.y >>> SHIFT;
    vec_nxt.zero = vin.zero;
    if (vin.y < 0) begin
      vec_nxt.x = vin.x - dy;
      vec_nxt.y = vin.y + dx;
      vec_nxt.z = vin.z - ZW'(ANGLE);
    end else begin
      vec_nxt.x = vin.x + dy;
      vec_nxt.y = vin.y - dx;
      vec_nxt.z = vin.z + ZW'(ANGLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vout = vec_r;

endmodule

// ===== src/sbpm_phase.sv =====
// Pipelined phase unit: half-plane fold, twenty CORDIC stages, then rounding to
// a 16-bit turn fraction offset by a quarter turn. Depends on sbpm_pkg and
// sbpm_cordic_stage.
module sbpm_phase import sbpm_pkg::*; (
  input  logic                     clk,
  input  logic [PH_STAGES-1:0]     en,
  input  logic signed [PART_W-1:0] re,
  input  logic signed [PART_W-1:0] im,
  output logic [PHASE_W-1:0]       phase
);

  cordic_vec_t pre_r, pre_nxt;
  cordic_vec_t stg [ITER+1];
  logic signed [XW-1:0] re_x, im_x;
  logic signed [ZW-1:0] z_rnd;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;

  // fold left half-plane onto the right, starting at half a turn
  always_comb begin
    re_x = XW'(re);
    im_x = XW'(im);
    pre_nxt.zero = (re == '0) && (im == '0);
    if (re < 0) begin
      pre_nxt.x = -re_x;
      pre_nxt.y = -im_x;
      pre_nxt.z = HALF_TURN;
    end else begin
      pre_nxt.x = re_x;
      pre_nxt.y = im_x;
      pre_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pre_r <= pre_nxt;
    end
  end

  assign stg[0] = pre_r;

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    sbpm_cordic_stage #(
      .SHIFT (i),
      .ANGLE (CORDIC_ANGLE[i])
    ) u_stage (
      .clk  (clk),
      .en   (en[i+1]),
      .vin  (stg[i]),
      .vout (stg[i+1])
    );
  end

  // bits 23:8 of the rounded angle; whole turns above bit 23 drop out
  always_comb begin
    z_rnd = stg[ITER].z + ROUND_BIAS;
    if (stg[ITER].zero) begin
      phase_nxt = QUARTER_TURN;
    end else begin
      phase_nxt = z_rnd[23:8] + QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en[PH_STAGES-1]) begin
      phase_r <= phase_nxt;
    end
  end

  assign phase = phase_r;

endmodule

// ===== src/sbpm_checker.sv =====
// Port-level checks for stereo_bin_phase_masker_core, bound to the top level.
// Depends on sbpm_pkg.
module sbpm_checker import sbpm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [PART_W-1:0] out_left_real,
  input logic signed [PART_W-1:0] out_left_imag,
  input logic signed [PART_W-1:0] out_right_real,
  input logic signed [PART_W-1:0] out_right_imag,
  input logic                     out_removed
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // an empty output register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with output empty");

  // a removed bin carries all-zero parts
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed |-> out_left_real == '0 && out_left_imag == '0 &&
                                 out_right_real == '0 && out_right_imag == '0)
    else $error("removed bin with non-zero parts");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed) &&
      $stable(out_left_real) && $stable(out_left_imag) &&
      $stable(out_right_real) && $stable(out_right_imag))
    else $error("stalled result changed");

endmodule

bind stereo_bin_phase_masker_core sbpm_checker u_sbpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_left_real  (out_left_real),
  .out_left_imag  (out_left_imag),
  .out_right_real (out_right_real),
  .out_right_imag (out_right_imag),
  .out_removed    (out_removed)
);

// ===== sim/testbench.sv =====
// Testbench for stereo_bin_phase_masker_core: directed and random bins through a
// valid/ready stream, checked against a CORDIC phase predictor kept in this file.
// Depends on sbpm_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpm_pkg::*;

  localparam int BINS        = DEF_BIN_COUNT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUARTER     = 16384;
  localparam int SETTLE      = PIPE_DEPTH + 4;

  typedef struct packed {
    logic signed [PART_W-1:0] left_real;
    logic signed [PART_W-1:0] left_imag;
    logic signed [PART_W-1:0] right_real;
    logic signed [PART_W-1:0] right_imag;
    logic                     removed;
  } bin_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic signed [PART_W-1:0] in_left_real  = '0;
  logic signed [PART_W-1:0] in_left_imag  = '0;
  logic signed [PART_W-1:0] in_right_real = '0;
  logic signed [PART_W-1:0] in_right_imag = '0;
  logic [BIN_W-1:0]         in_bin_number = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [PART_W-1:0] out_left_real;
  logic signed [PART_W-1:0] out_left_imag;
  logic signed [PART_W-1:0] out_right_real;
  logic signed [PART_W-1:0] out_right_imag;
  logic                     out_removed;
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [CFG_W-1:0]         cfg_wdata     = '0;

  // predictor copy of the two registers
  logic [THR_W-1:0] threshold_copy = '0;
  logic [BIN_W-1:0] cutoff_copy    = '0;

  // atan(2^-i) in 2^-24 turn
  longint atan_turn [0:19] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  bin_result_t expected_bins [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  stereo_bin_phase_masker_core #(
    .BIN_COUNT(BINS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_left_real  (in_left_real),
    .in_left_imag  (in_left_imag),
    .in_right_real (in_right_real),
    .in_right_imag (in_right_imag),
    .in_bin_number (in_bin_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_real (out_left_real),
    .out_left_imag (out_left_imag),
    .out_right_real(out_right_real),
    .out_right_imag(out_right_imag),
    .out_removed   (out_removed),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // vectoring CORDIC, phase in 1/65536 turn with a quarter turn added
  function automatic logic [PHASE_W-1:0] bin_phase(longint re, longint im);
    longint x, y, z, dx, dy;
    x = re;
    y = im;
    z = 0;
    if (x == 0 && y == 0) return PHASE_W'(QUARTER);
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd8388608;
    end
    for (int i = 0; i < 20; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y < 0) begin
        x = x - dy;
        y = y + dx;
        z = z - atan_turn[i];
      end else begin
        x = x + dy;
        y = y - dx;
        z = z + atan_turn[i];
      end
    end
    // four whole turns keep the shift on a positive value
    return PHASE_W'(((z + 64'sd67108864 + 128) >>> 8) + QUARTER);
  endfunction

  function automatic bin_result_t predict_bin(bin_payload_t p);
    logic [PHASE_W-1:0] pl, pr;
    int                 diff;
    logic               drop;
    bin_result_t        r;
    pl = bin_phase(longint'(p.left_real), longint'(p.left_imag));
    pr = bin_phase(longint'(p.right_real), longint'(p.right_imag));
    diff = (pl >= pr) ? int'(pl) - int'(pr) : int'(pr) - int'(pl);
    drop = (diff < int'(threshold_copy)) && (int'(p.bin_number) > int'(cutoff_copy)) &&
           (p.bin_number != '0) && (int'(p.bin_number) < BINS);
    r.left_real  = drop ? '0 : p.left_real;
    r.left_imag  = drop ? '0 : p.left_imag;
    r.right_real = drop ? '0 : p.right_real;
    r.right_imag = drop ? '0 : p.right_imag;
    r.removed    = drop;
    return r;
  endfunction

  function automatic bin_payload_t make_bin(int lr, int li, int rr, int ri, int bin);
    bin_payload_t p;
    p.left_real  = PART_W'(lr);
    p.left_imag  = PART_W'(li);
    p.right_real = PART_W'(rr);
    p.right_imag = PART_W'(ri);
    p.bin_number = BIN_W'(bin);
    return p;
  endfunction

  function automatic logic signed [PART_W-1:0] random_part();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 24'sh800000;
          1: return 24'sh7FFFFF;
          2: return '0;
          default: return 24'shFFFFFF;
        endcase
      end
      1: return PART_W'($urandom_range(0, 510)) - PART_W'(255);
      default: return PART_W'($urandom);
    endcase
  endfunction

  // mostly pairs with near-equal phase so removal is reached often
  function automatic bin_payload_t random_bin_item();
    bin_payload_t p;
    int           k;
    p.left_real  = random_part();
    p.left_imag  = random_part();
    p.bin_number = BIN_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 9))
      0, 1: begin
        p.right_real = p.left_real;
        p.right_imag = p.left_imag;
      end
      2, 3: begin
        k = $urandom_range(1, 12);
        p.right_real = p.left_real >>> k;
        p.right_imag = p.left_imag >>> k;
      end
      4, 5: begin
        p.right_real = p.left_real + PART_W'($urandom_range(0, 64)) - PART_W'(32);
        p.right_imag = p.left_imag + PART_W'($urandom_range(0, 64)) - PART_W'(32);
      end
      default: begin
        p.right_real = random_part();
        p.right_imag = random_part();
      end
    endcase
    return p;
  endfunction

  function automatic int unsigned random_threshold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return $urandom_range(0, 2048);
      3: return $urandom_range(0, 65536);
      4: return 65535;
      5: return 65536;
      6: return 131071;
      default: return $urandom_range(100, 20000);
    endcase
  endfunction

  function automatic void check_part(string name, logic signed [PART_W-1:0] want,
                                     logic signed [PART_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = expected_bins.pop_front();
        check_part("out_left_real", want.left_real, out_left_real);
        check_part("out_left_imag", want.left_imag, out_left_imag);
        check_part("out_right_real", want.right_real, out_right_real);
        check_part("out_right_imag", want.right_imag, out_right_imag);
        check_part("out_removed", PART_W'(want.removed), PART_W'(out_removed));
      end
    end
  end

  // entered and left at a falling edge; valid stays high on return
  task automatic send_bin(bin_payload_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_left_real  <= p.left_real;
    in_left_imag  <= p.left_imag;
    in_right_real <= p.right_real;
    in_right_imag <= p.right_imag;
    in_bin_number <= p.bin_number;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    expected_bins.push_back(predict_bin(p));
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_THRESHOLD: threshold_copy = THR_W'(value);
      REG_CUTOFF_BIN:      cutoff_copy    = BIN_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // threshold resets to 0, so even identical phases must pass
  task automatic test_reset_state();
    send_bin(make_bin(1000, 2000, 1000, 2000, 5));
    send_bin(make_bin(0, 0, 0, 0, 900));
    send_bin(random_bin_item());
    settle();
  endtask

  task automatic test_phase_extremes();
    write_reg(REG_PHASE_THRESHOLD, 65536);
    write_reg(REG_CUTOFF_BIN, 0);
    send_bin(make_bin(0, 0, 0, 0, 1));                      // zero vectors
    send_bin(make_bin(0, 0, 0, 0, 0));                      // DC bin
    send_bin(make_bin(8388607, 8388607, 8388607, 8388607, 1023));
    send_bin(make_bin(-8388608, -8388608, -8388608, -8388608, 512));
    send_bin(make_bin(-8388608, 0, 8388607, 0, 3));         // half a turn apart
    send_bin(make_bin(0, -8388608, 0, 8388607, 4));         // real zero, imag signs
    send_bin(make_bin(-1, -1, 1, 1, 2));
    send_bin(make_bin(1, -8388608, -1, -8388608, 6));       // either side of the wrap
    settle();
  endtask

  task automatic test_threshold_range();
    write_reg(REG_PHASE_THRESHOLD, 0);
    send_bin(make_bin(1000, 2000, 1000, 2000, 7));
    settle();
    write_reg(REG_PHASE_THRESHOLD, 1);
    send_bin(make_bin(1000, 2000, 1000, 2000, 7));
    send_bin(make_bin(1, -8388608, -1, -8388608, 9));
    settle();
    write_reg(REG_PHASE_THRESHOLD, 65535);
    send_bin(make_bin(1, -8388608, -1, -8388608, 9));
    send_bin(make_bin(8388607, 0, -8388608, 0, 10));
    settle();
    write_reg(REG_PHASE_THRESHOLD, 131071);
    send_bin(make_bin(1, -8388608, -1, -8388608, 1023));
    settle();
  endtask

  task automatic test_cutoff_boundary();
    write_reg(REG_CUTOFF_BIN, 100);
    send_bin(make_bin(-5, 77, 300, -4000, 100));
    send_bin(make_bin(-5, 77, 300, -4000, 101));
    send_bin(make_bin(-5, 77, 300, -4000, 0));
    settle();
    write_reg(REG_CUTOFF_BIN, 1023);
    send_bin(make_bin(8388607, -8388608, 12, 34, 1023));
    settle();
    write_reg(REG_CUTOFF_BIN, 0);
    send_bin(make_bin(8388607, -8388608, 12, 34, 1));
    send_bin(make_bin(8388607, -8388608, 12, 34, 0));
    settle();
  endtask

  task automatic test_random_bins(int idle, int stall, int per_setting);
    int unsigned cutoff;
    idle_pct  = idle;
    stall_pct = stall;
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(0, 3))
        0: cutoff = 0;
        1: cutoff = 1023;
        2: cutoff = $urandom_range(0, 1023);
        default: cutoff = $urandom_range(0, 64);
      endcase
      write_reg(REG_PHASE_THRESHOLD, random_threshold());
      write_reg(REG_CUTOFF_BIN, cutoff);
      for (int n = 0; n < per_setting; n++) send_bin(random_bin_item());
      settle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_phase_extremes();
    test_threshold_range();
    test_cutoff_boundary();
    test_random_bins(0, 0, 50);
    test_random_bins(81, 0, 50);
    test_random_bins(0, 81, 50);
    test_random_bins(29, 29, 50);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
